// ===== hdl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_LAT       = COORD_BITS + 2;
  localparam int NUM_REGS      = 6;
  localparam int ADDR_BITS     = 5;
  localparam int IDX_BITS      = 3;

  localparam logic [IDX_BITS-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic signed [COORD_BITS-1:0] VAL_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] VAL_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] direction_x;
    logic signed [COORD_BITS-1:0] direction_y;
    logic signed [COORD_BITS-1:0] direction_z;
    logic signed [COORD_BITS-1:0] interval_start;
    logic signed [COORD_BITS-1:0] interval_end;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] t_enter;
    logic signed [COORD_BITS-1:0] t_exit;
  } out_item_t;

endpackage

// ===== hdl/rbs_div.sv =====
module rbs_div #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic signed [rbs_pkg::COORD_BITS-1:0] plane,
  input  logic signed [rbs_pkg::COORD_BITS-1:0] org,
  input  logic signed [rbs_pkg::COORD_BITS-1:0] dir,
  output logic signed [rbs_pkg::COORD_BITS-1:0] t_dist
);
  import rbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int RW = 2 * CB + FRAC_BITS;
  localparam int QW = CB - 1;

  logic signed [CB:0] diff;
  logic signed [CB:0] dext;
  logic        [CB:0] diff_abs;
  logic        [CB:0] dir_abs;

  logic          neg0_r;
  logic [CB-1:0] nmag0_r;
  logic [CB-1:0] dmag0_r;

  logic [RW-1:0] num1;
  logic [RW-1:0] lim1;

  logic [RW-1:0] rem_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [CB-1:0] dmag_r [QW+1];
  logic          neg_r  [QW+1];
  logic          sat_r  [QW+1];

  logic signed [CB-1:0] dist_r;

  assign diff     = {plane[CB-1], plane} - {org[CB-1], org};
  assign dext     = {dir[CB-1], dir};
  assign diff_abs = diff[CB] ? -diff : diff;
  assign dir_abs  = dext[CB] ? -dext : dext;

  always_ff @(posedge clk) begin
    neg0_r  <= diff[CB] ^ dir[CB-1];
    nmag0_r <= diff_abs[CB-1:0];
    dmag0_r <= dir_abs[CB-1:0];
  end

  assign num1 = RW'(nmag0_r) << FRAC_BITS;
  assign lim1 = RW'(dmag0_r) << (CB - 1);

  always_ff @(posedge clk) begin
    rem_r[0]  <= num1;
    quo_r[0]  <= '0;
    dmag_r[0] <= dmag0_r;
    neg_r[0]  <= neg0_r;
    sat_r[0]  <= (num1 >= lim1);
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          ge;
    logic [QW-1:0] quo_nxt;

    assign trial = RW'(dmag_r[k]) << BIT;
    assign ge    = (rem_r[k] >= trial);

    always_comb begin
      quo_nxt      = quo_r[k];
      quo_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? rem_r[k] - trial : rem_r[k];
      quo_r[k+1]  <= quo_nxt;
      dmag_r[k+1] <= dmag_r[k];
      neg_r[k+1]  <= neg_r[k];
      sat_r[k+1]  <= sat_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (sat_r[QW]) begin
      dist_r <= neg_r[QW] ? VAL_MIN : VAL_MAX;
    end else if (neg_r[QW]) begin
      dist_r <= -$signed({1'b0, quo_r[QW]});
    end else begin
      dist_r <= $signed({1'b0, quo_r[QW]});
    end
  end

  assign t_dist = dist_r;

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// Channel        Ports                                Handshake
// input          start, busy, in_data                 taken when start is high and busy is low
// result         out_valid, out_data                  shown for one cycle, cannot be held off
// configuration  psel, penable, pwrite, paddr, ...    written in the access cycle
//
// One transaction is accepted in every cycle; busy stays low and the receiver cannot stall.
// Each result is strobed once its transaction has passed the one-bit-per-stage divider
// pipelines, one for each of the six slab planes, and then the slab sort, interval
// merge and output registers.
// Synchronous active-low reset clears the valid bits and the box registers.
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rbs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output rbs_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbs_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import rbs_pkg::*;

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0] box_r [NUM_REGS];
  logic [IDX_BITS-1:0]  reg_idx;
  logic                 accept;

  logic signed [CB-1:0] org   [3];
  logic signed [CB-1:0] dirv  [3];
  logic signed [CB-1:0] t_a   [3];
  logic signed [CB-1:0] t_b   [3];
  logic [2:0]           dz_in;
  logic                 ok_in;

  logic                 vld_r   [DIV_LAT];
  logic [2:0]           dz_r    [DIV_LAT];
  logic                 ok_r    [DIV_LAT];
  logic signed [CB-1:0] lo_r    [DIV_LAT];
  logic signed [CB-1:0] hi_r    [DIV_LAT];

  logic signed [CB-1:0] near_nxt [3];
  logic signed [CB-1:0] far_nxt  [3];
  logic signed [CB-1:0] near_r   [3];
  logic signed [CB-1:0] far_r    [3];
  logic                 vld_a_r, ok_a_r;
  logic signed [CB-1:0] lo_a_r, hi_a_r;

  logic signed [CB-1:0] m0, m1, n0, n1;
  logic                 vld_b_r, ok_b_r;
  logic signed [CB-1:0] lo_b_r, hi_b_r;

  logic                 hit_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign accept  = start && !busy;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign prdata  = (reg_idx < IDX_BITS'(NUM_REGS)) ? box_r[reg_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        box_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_BOX_MIN_X: box_r[0] <= pwdata;
        REG_BOX_MIN_Y: box_r[1] <= pwdata;
        REG_BOX_MIN_Z: box_r[2] <= pwdata;
        REG_BOX_MAX_X: box_r[3] <= pwdata;
        REG_BOX_MAX_Y: box_r[4] <= pwdata;
        REG_BOX_MAX_Z: box_r[5] <= pwdata;
        default: ;
      endcase
    end
  end

  assign org[0]  = in_data.origin_x;
  assign org[1]  = in_data.origin_y;
  assign org[2]  = in_data.origin_z;
  assign dirv[0] = in_data.direction_x;
  assign dirv[1] = in_data.direction_y;
  assign dirv[2] = in_data.direction_z;

  always_comb begin
    ok_in = (in_data.interval_start <= in_data.interval_end);
    for (int a = 0; a < 3; a++) begin
      dz_in[a] = (dirv[a] == '0);
      if (dz_in[a] && (org[a] < box_r[a] || org[a] > box_r[a+3])) begin
        ok_in = 1'b0;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
      .clk(clk), .plane(box_r[a]), .org(org[a]), .dir(dirv[a]), .t_dist(t_a[a])
    );
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
      .clk(clk), .plane(box_r[a+3]), .org(org[a]), .dir(dirv[a]), .t_dist(t_b[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dz_r[0] <= dz_in;
    ok_r[0] <= ok_in;
    lo_r[0] <= in_data.interval_start;
    hi_r[0] <= in_data.interval_end;
    for (int i = 1; i < DIV_LAT; i++) begin
      dz_r[i] <= dz_r[i-1];
      ok_r[i] <= ok_r[i-1];
      lo_r[i] <= lo_r[i-1];
      hi_r[i] <= hi_r[i-1];
    end
  end

  // An axis with zero direction leaves the interval alone.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dz_r[DIV_LAT-1][a]) begin
        near_nxt[a] = VAL_MIN;
        far_nxt[a]  = VAL_MAX;
      end else if (t_a[a] > t_b[a]) begin
        near_nxt[a] = t_b[a];
        far_nxt[a]  = t_a[a];
      end else begin
        near_nxt[a] = t_a[a];
        far_nxt[a]  = t_b[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r <= vld_r[DIV_LAT-1];
      vld_b_r <= vld_a_r;
      out_valid_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    near_r <= near_nxt;
    far_r  <= far_nxt;
    ok_a_r <= ok_r[DIV_LAT-1];
    lo_a_r <= lo_r[DIV_LAT-1];
    hi_a_r <= hi_r[DIV_LAT-1];
  end

  assign m0 = (near_r[0] > lo_a_r) ? near_r[0] : lo_a_r;
  assign m1 = (near_r[2] > near_r[1]) ? near_r[2] : near_r[1];
  assign n0 = (far_r[0] < hi_a_r) ? far_r[0] : hi_a_r;
  assign n1 = (far_r[2] < far_r[1]) ? far_r[2] : far_r[1];

  always_ff @(posedge clk) begin
    ok_b_r <= ok_a_r;
    lo_b_r <= (m1 > m0) ? m1 : m0;
    hi_b_r <= (n1 < n0) ? n1 : n0;
  end

  assign hit_nxt = ok_b_r && (lo_b_r <= hi_b_r);

  always_ff @(posedge clk) begin
    out_data_r.hit     <= hit_nxt;
    out_data_r.t_enter <= hit_nxt ? lo_b_r : '0;
    out_data_r.t_exit  <= hit_nxt ? hi_b_r : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, DIV_LAT + 3))
    else $error("result without a transaction at the expected latency");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.t_enter == '0 && out_data.t_exit == '0))
    else $error("miss carries non-zero distances");
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (out_data.t_enter <= out_data.t_exit))
    else $error("hit with entry beyond exit");
`endif

endmodule
